>>> rtl/oile_pkg.sv
// shared types and constants of the ordered id list engine
package oile_pkg;

	localparam int OP_W       = 3;
	localparam int FIELD_ID_W = 16;
	localparam int STATUS_W   = 2;
	localparam int OUT_CNT_W  = 5;

	// request codes; codes above search leave the list unchanged and answer with status ok
	typedef enum logic [OP_W-1:0] {
		OP_FRONT  = 3'd0,
		OP_BACK   = 3'd1,
		OP_AFTER  = 3'd2,
		OP_REMOVE = 3'd3,
		OP_SEARCH = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} st_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_WALK,
		S_INS,
		S_LINK,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch_in;
		logic start_walk;
		logic walk_step;
		logic ins;
		logic link2;
		logic remove;
		logic res_set;
		logic res_found;
		logic load_out;
		st_t  res_code;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic hit;
		logic last;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/oile_ctrl.sv
// sequencing state machine of the ordered id list engine
module oile_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  oile_pkg::sts_t sts,
	output oile_pkg::cmd_t cmd
);
	import oile_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.res_code = ST_OK;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_nxt    = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.op)
					OP_FRONT, OP_BACK: begin
						if (sts.full) begin
							cmd.res_set  = 1'b1;
							cmd.res_code = ST_FULL;
							state_nxt    = S_DONE;
						end else begin
							state_nxt = S_INS;
						end
					end
					OP_AFTER, OP_REMOVE, OP_SEARCH: begin
						if (sts.empty) begin
							cmd.res_set  = 1'b1;
							cmd.res_code = ST_NOT_FOUND;
							state_nxt    = S_DONE;
						end else begin
							cmd.start_walk = 1'b1;
							state_nxt      = S_WALK;
						end
					end
					default: begin
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_OK;
						state_nxt    = S_DONE;
					end
				endcase
			end
			S_WALK: begin
				if (sts.hit) begin
					case (sts.op)
						OP_REMOVE: begin
							cmd.remove = 1'b1;
							state_nxt  = S_DONE;
						end
						OP_AFTER: begin
							if (sts.full) begin
								cmd.res_set  = 1'b1;
								cmd.res_code = ST_FULL;
								state_nxt    = S_DONE;
							end else begin
								state_nxt = S_INS;
							end
						end
						default: begin
							cmd.res_found = 1'b1;
							state_nxt     = S_DONE;
						end
					endcase
				end else if (sts.last) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_NOT_FOUND;
					state_nxt    = S_DONE;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_INS: begin
				cmd.ins   = 1'b1;
				state_nxt = (sts.op == OP_AFTER) ? S_LINK : S_DONE;
			end
			S_LINK: begin
				cmd.link2 = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/oile_dp.sv
// list stores, walk registers, slot allocation and result register
module oile_dp #(
	parameter int CAPACITY = 16,
	parameter int ID_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  oile_pkg::cmd_t                      cmd,
	input  logic [oile_pkg::OP_W-1:0]           operation,
	input  logic [oile_pkg::FIELD_ID_W-1:0]     vehicle_id,
	input  logic [oile_pkg::FIELD_ID_W-1:0]     anchor_id,
	output oile_pkg::sts_t                      sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [oile_pkg::STATUS_W-1:0]       status,
	output logic [oile_pkg::OUT_CNT_W-1:0]      position,
	output logic [oile_pkg::OUT_CNT_W-1:0]      entry_count
);
	import oile_pkg::*;

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	logic [ID_BITS-1:0] id_mem   [CAPACITY];
	logic [SLOT_W-1:0]  link_mem [CAPACITY];
	logic [SLOT_W-1:0]  fstk_mem [CAPACITY];

	op_t                op_q;
	logic [ID_BITS-1:0] key_q;
	logic [ID_BITS-1:0] anchor_q;

	logic [SLOT_W-1:0]  head_q;
	logic [SLOT_W-1:0]  tail_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   fresh_q;
	logic [CNT_W-1:0]   sp_q;

	logic [SLOT_W-1:0]  cur_q;
	logic [SLOT_W-1:0]  prev_q;
	logic               prev_vld_q;
	logic [CNT_W-1:0]   idx_q;
	logic [SLOT_W-1:0]  n_q;
	logic [ID_BITS-1:0] id_rd_q;
	logic [SLOT_W-1:0]  link_rd_q;
	logic [SLOT_W-1:0]  fstk_rd_q;

	st_t                res_status_q;
	logic [CNT_W-1:0]   res_pos_q;
	logic               out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [OUT_CNT_W-1:0] out_pos_q;
	logic [OUT_CNT_W-1:0] out_cnt_q;

	logic               rd_en;
	logic [SLOT_W-1:0]  rd_addr;
	logic [SLOT_W-1:0]  new_slot;
	logic [CNT_W-1:0]   sp_dec;
	logic               lw_en;
	logic [SLOT_W-1:0]  lw_addr;
	logic [SLOT_W-1:0]  lw_data;
	logic [ID_BITS-1:0] target;
	logic [31:0]        pos_ext;
	logic [31:0]        cnt_ext;

	assign rd_en    = cmd.start_walk | cmd.walk_step;
	assign rd_addr  = cmd.start_walk ? head_q : link_rd_q;
	assign new_slot = (sp_q != '0) ? fstk_rd_q : fresh_q[SLOT_W-1:0];
	assign sp_dec   = sp_q - 1'b1;
	assign target   = (op_q == OP_AFTER) ? anchor_q : key_q;

	// one link write per cycle at most
	always_comb begin
		lw_en   = 1'b0;
		lw_addr = cur_q;
		lw_data = link_rd_q;
		if (cmd.remove && prev_vld_q) begin
			lw_en   = 1'b1;
			lw_addr = prev_q;
			lw_data = link_rd_q;
		end
		if (cmd.ins) begin
			case (op_q)
				OP_FRONT: begin
					lw_en   = 1'b1;
					lw_addr = new_slot;
					lw_data = head_q;
				end
				OP_BACK: begin
					lw_en   = (count_q != '0);
					lw_addr = tail_q;
					lw_data = new_slot;
				end
				OP_AFTER: begin
					lw_en   = 1'b1;
					lw_addr = new_slot;
					lw_data = link_rd_q;
				end
				default: begin
					lw_en = 1'b0;
				end
			endcase
		end
		if (cmd.link2) begin
			lw_en   = 1'b1;
			lw_addr = cur_q;
			lw_data = n_q;
		end
	end

	// stores
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			id_mem[new_slot] <= key_q;
		end
		if (lw_en) begin
			link_mem[lw_addr] <= lw_data;
		end
		if (cmd.remove) begin
			fstk_mem[sp_q[SLOT_W-1:0]] <= cur_q;
		end
		if (rd_en) begin
			id_rd_q   <= id_mem[rd_addr];
			link_rd_q <= link_mem[rd_addr];
		end
		fstk_rd_q <= fstk_mem[sp_dec[SLOT_W-1:0]];
	end

	// list control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			fresh_q <= '0;
			sp_q    <= '0;
		end else begin
			if (cmd.ins) begin
				count_q <= count_q + 1'b1;
				if (sp_q != '0) begin
					sp_q <= sp_dec;
				end else begin
					fresh_q <= fresh_q + 1'b1;
				end
				case (op_q)
					OP_FRONT: begin
						head_q <= new_slot;
						if (count_q == '0) begin
							tail_q <= new_slot;
						end
					end
					OP_BACK: begin
						if (count_q == '0) begin
							head_q <= new_slot;
						end
						tail_q <= new_slot;
					end
					default: begin
					end
				endcase
			end
			if (cmd.link2 && (cur_q == tail_q)) begin
				tail_q <= n_q;
			end
			if (cmd.remove) begin
				count_q <= count_q - 1'b1;
				sp_q    <= sp_q + 1'b1;
				if (!prev_vld_q) begin
					head_q <= link_rd_q;
				end
				if (cur_q == tail_q) begin
					tail_q <= prev_vld_q ? prev_q : '0;
				end
				if (count_q == CNT_W'(1)) begin
					head_q <= '0;
					tail_q <= '0;
				end
			end
		end
	end

	// request, walk and result registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q     <= op_t'(operation);
			key_q    <= ID_BITS'(vehicle_id);
			anchor_q <= ID_BITS'(anchor_id);
		end
		if (cmd.start_walk) begin
			cur_q      <= head_q;
			prev_vld_q <= 1'b0;
			idx_q      <= CNT_W'(1);
		end
		if (cmd.walk_step) begin
			prev_q     <= cur_q;
			prev_vld_q <= 1'b1;
			cur_q      <= link_rd_q;
			idx_q      <= idx_q + 1'b1;
		end
		if (cmd.ins) begin
			n_q          <= new_slot;
			res_status_q <= ST_OK;
			case (op_q)
				OP_BACK:  res_pos_q <= count_q + 1'b1;
				OP_AFTER: res_pos_q <= idx_q + 1'b1;
				default:  res_pos_q <= CNT_W'(1);
			endcase
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_code;
			res_pos_q    <= '0;
		end
		if (cmd.res_found || cmd.remove) begin
			res_status_q <= ST_OK;
			res_pos_q    <= idx_q;
		end
	end

	// output register
	assign pos_ext = 32'(res_pos_q);
	assign cnt_ext = 32'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_pos_q    <= pos_ext[OUT_CNT_W-1:0];
			out_cnt_q    <= cnt_ext[OUT_CNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign position    = out_pos_q;
	assign entry_count = out_cnt_q;

	assign sts.op       = op_q;
	assign sts.full     = (count_q == CNT_W'(CAPACITY));
	assign sts.empty    = (count_q == '0);
	assign sts.hit      = (id_rd_q == target);
	assign sts.last     = (idx_q == count_q);
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

>>> rtl/ordered_id_list_engine.sv
// top level of the ordered id list engine: stream ports, controller and datapath
// insert at front or back passes dispatch, insert and done before its result is registered;
//   search, remove and insert-after walk one list entry per cycle through the link store,
//   and insert-after then writes the new entry and relinks the anchor to it before done
// throughput: one item at a time; a new request is taken only once the last result is in the output register
// reset: arst_n empties the list at once; the id and link stores are not cleared
module ordered_id_list_engine #(
	parameter int CAPACITY = 16,
	parameter int ID_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// request items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // operation[2:0], vehicle_id[18:3], anchor_id[34:19], zero pad
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // status[1:0], position[6:2], entry_count[11:7], zero pad
);
	import oile_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// request fields
	logic [OP_W-1:0]       operation;
	logic [FIELD_ID_W-1:0] vehicle_id;
	logic [FIELD_ID_W-1:0] anchor_id;

	// result fields
	logic [STATUS_W-1:0]  status;
	logic [OUT_CNT_W-1:0] position;
	logic [OUT_CNT_W-1:0] entry_count;

	assign operation  = s_tdata[2:0];
	assign vehicle_id = s_tdata[18:3];
	assign anchor_id  = s_tdata[34:19];

	// sequencer: dispatch, walk, insert, relink, hand over result
	oile_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// stores, free slot stack and output register
	oile_dp #(
		.CAPACITY (CAPACITY),
		.ID_BITS  (ID_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.operation   (operation),
		.vehicle_id  (vehicle_id),
		.anchor_id   (anchor_id),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.status      (status),
		.position    (position),
		.entry_count (entry_count)
	);

	// result packing, lowest field first
	assign m_tdata = {4'b0000, entry_count, position, status};

endmodule
